@@ rtl/conv5_pkg.sv @@
// Shared types and constants for the streaming 5x5 convolution filter.
// Holds kernel geometry, sample and arithmetic widths and the register map.
// No dependencies.
`default_nettype none

package conv5_pkg;

  // Kernel geometry.
  localparam int unsigned KERNEL = 5;
  localparam int unsigned TAPS   = KERNEL * KERNEL;
  localparam int unsigned LINES  = KERNEL - 1;

  // Field widths.
  localparam int unsigned PIX_W   = 16;
  localparam int unsigned COEF_W  = 16;
  localparam int unsigned FRAC_W  = 15;
  localparam int unsigned CFG_W   = 64;
  localparam int unsigned IDX_W   = 3;
  localparam int unsigned IMG_W_W = 11;

  // Register map.
  localparam logic [IDX_W-1:0] REG_IMAGE_WIDTH = 3'd0;
  localparam logic [IDX_W-1:0] REG_COEF_A      = 3'd1;
  localparam logic [IDX_W-1:0] REG_COEF_G      = 3'd7;
  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET = 11'd1024;

  // Sample, coefficient and partial-sum types.
  typedef logic [PIX_W-1:0]         pix_t;
  typedef logic signed [COEF_W-1:0] coef_t;
  typedef logic [LINES*PIX_W-1:0]   line_word_t;
  // Unsigned 16-bit sample times signed Q1.15 coefficient.
  typedef logic signed [PIX_W+COEF_W:0] prod_t;
  // Sum of one kernel row of five products.
  typedef logic signed [PIX_W+COEF_W+3:0] row_sum_t;
  // Sum of all 25 products.
  typedef logic signed [PIX_W+COEF_W+6:0] acc_t;
  // Base addend plus shifted sum, before saturation.
  typedef logic signed [33:0] total_t;

endpackage

`default_nettype wire

@@ rtl/conv5x5_stream_filter.sv @@
// Top level of the streaming 5x5 convolution filter.
// Line store memory, window registers, multiplier and adder pipeline.
// Depends on conv5_pkg.
`default_nettype none

// Streaming 5x5 convolution over a square raster image, one pixel per beat.
// The block takes one pixel per clock for as long as the result side keeps
// up, and a beat that completes a valid window yields a result through the
// stage registers. Throughput is set by the single line store memory, which is
// read for a column when its pixel is taken and written back one stage later;
// the multiplier bank, two adder stages and the saturating output stage
// are fully pipelined. Stages with no result in flight absorb a stalled output,
// so input beats continue to be taken while a result waits. After reset the
// line store is cleared in a pass over all MAX_WIDTH words, while in_stall
// is high; configuration writes are taken at all times.
module conv5x5_stream_filter
  import conv5_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  // Pixel input channel
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic [PIX_W-1:0]          in_pixel,
  input  wire logic signed [31:0]        in_base_addend,
  input  wire logic                      in_frame_start,
  // Result channel
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output logic signed [31:0]             out_filtered,
  output logic                           out_row_last,
  output logic                           out_frame_last,
  // Configuration write channel
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [IDX_W-1:0]          cfg_index,
  input  wire logic [CFG_W-1:0]          cfg_data
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [IMG_W_W-1:0] img_width_r;
  coef_t              coef_r [TAPS];
  logic               cfg_acc;

  assign cfg_ready = 1'b1;
  assign cfg_acc   = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      img_width_r <= IMAGE_WIDTH_RESET;
      for (int t = 0; t < TAPS; t++) begin
        coef_r[t] <= '0;
      end
    end else if (cfg_acc) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        img_width_r <= cfg_data[IMG_W_W-1:0];
      end
      // Packs A to F carry four taps each; pack G carries the last tap.
      for (int t = 0; t < TAPS - 1; t++) begin
        if (cfg_index == REG_COEF_A + IDX_W'(t / 4)) begin
          coef_r[t] <= coef_t'(cfg_data[COEF_W*(t % 4) +: COEF_W]);
        end
      end
      if (cfg_index == REG_COEF_G) begin
        coef_r[TAPS-1] <= coef_t'(cfg_data[COEF_W-1:0]);
      end
    end
  end

  // Width in use, clamped to the kernel size and the line store depth.
  logic [WW-1:0] width_use;

  always_comb begin
    if (int'(img_width_r) > int'(MAX_WIDTH)) begin
      width_use = WW'(MAX_WIDTH);
    end else if (int'(img_width_r) < int'(KERNEL)) begin
      width_use = WW'(KERNEL);
    end else begin
      width_use = WW'(img_width_r);
    end
  end

  // ---------------------------------------------------------------------
  // Pipeline handshake: each stage advances when the next one has room
  // ---------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, s3_valid_r, s4_valid_r, out_valid_r;
  logic s1_prod_r;
  logic out_rdy, s4_rdy, s3_rdy, s2_rdy, s1_adv, s1_rdy;
  logic clear_r;
  logic in_acc;

  assign out_rdy  = !out_valid_r || !out_stall;
  assign s4_rdy   = !s4_valid_r || out_rdy;
  assign s3_rdy   = !s3_valid_r || s4_rdy;
  assign s2_rdy   = !s2_valid_r || s3_rdy;
  // An item that completes no window only needs to update the line store.
  assign s1_adv   = s1_valid_r && (!s1_prod_r || s2_rdy);
  assign s1_rdy   = !s1_valid_r || s1_adv;
  assign in_stall = clear_r || !s1_rdy;
  assign in_acc   = in_valid && !in_stall;

  // ---------------------------------------------------------------------
  // Raster position counters
  // ---------------------------------------------------------------------
  logic [CW-1:0] col_r, row_r;
  logic [CW-1:0] col_base, row_base, col_cur, row_cur;
  logic [CW-1:0] col_nxt, row_nxt;
  logic [WW-1:0] col_inc, row_inc;

  always_comb begin
    col_base = in_frame_start ? '0 : col_r;
    row_base = in_frame_start ? '0 : row_r;
    col_cur  = (WW'(col_base) >= width_use) ? '0 : col_base;
    row_cur  = (WW'(row_base) >= width_use) ? '0 : row_base;
    col_inc  = WW'(col_cur) + WW'(1);
    row_inc  = WW'(row_cur) + WW'(1);
    col_nxt  = col_cur + CW'(1);
    row_nxt  = row_cur;
    if (col_inc >= width_use) begin
      col_nxt = '0;
      row_nxt = (row_inc >= width_use) ? '0 : row_cur + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (in_acc) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Line store: one word per column holds the four previous rows,
  // oldest row in the low bits. Cleared by a pass after reset.
  // ---------------------------------------------------------------------
  line_word_t    line_mem [MAX_WIDTH];
  line_word_t    mem_q_r, fwd_word_r, rd_word, new_word, mem_wdata;
  logic          fwd_r;
  logic [CW-1:0] clr_addr_r, mem_waddr;
  logic          mem_we;

  // Stage 1 registers: the accepted beat and its position.
  pix_t               s1_px_r;
  logic signed [31:0] s1_base_r;
  logic [CW-1:0]      s1_col_r;
  logic               s1_row_last_r, s1_frame_last_r;

  // Clearing pass after reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clear_r    <= 1'b1;
      clr_addr_r <= '0;
    end else if (clear_r) begin
      clr_addr_r <= clr_addr_r + CW'(1);
      if (clr_addr_r == CW'(MAX_WIDTH - 1)) begin
        clear_r <= 1'b0;
      end
    end
  end

  // Shift the column up one row and put the new pixel in the newest row.
  assign rd_word   = fwd_r ? fwd_word_r : mem_q_r;
  assign new_word  = {s1_px_r, rd_word[LINES*PIX_W-1:PIX_W]};
  assign mem_we    = clear_r || s1_adv;
  assign mem_waddr = clear_r ? clr_addr_r : s1_col_r;
  assign mem_wdata = clear_r ? '0 : new_word;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      mem_q_r <= line_mem[col_cur];
    end
  end

  // Bypass for a column written back in the same cycle as it is read.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      fwd_r      <= s1_adv && (s1_col_r == col_cur);
      fwd_word_r <= new_word;
    end
  end

  // Stage 1 capture.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_rdy) begin
      s1_valid_r <= in_acc;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_px_r         <= in_pixel;
      s1_base_r       <= in_base_addend;
      s1_col_r        <= col_cur;
      s1_prod_r       <= (int'(row_cur) >= int'(LINES)) && (int'(col_cur) >= int'(LINES));
      s1_row_last_r   <= (col_inc == width_use);
      s1_frame_last_r <= (col_inc == width_use) && (row_inc == width_use);
    end
  end

  // ---------------------------------------------------------------------
  // 5x5 window: each row shifts left, the new column enters on the right
  // ---------------------------------------------------------------------
  pix_t win_r   [KERNEL][KERNEL];
  pix_t win_nxt [KERNEL][KERNEL];
  pix_t new_col [KERNEL];

  always_comb begin
    for (int k = 0; k < LINES; k++) begin
      new_col[k] = rd_word[PIX_W*k +: PIX_W];
    end
    new_col[LINES] = s1_px_r;
    for (int k = 0; k < KERNEL; k++) begin
      for (int l = 0; l < KERNEL - 1; l++) begin
        win_nxt[k][l] = win_r[k][l+1];
      end
      win_nxt[k][KERNEL-1] = new_col[k];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      win_r <= win_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: 25 products
  // ---------------------------------------------------------------------
  prod_t              prod_r [TAPS];
  logic signed [31:0] s2_base_r;
  logic               s2_row_last_r, s2_frame_last_r;
  logic               s2_load;

  assign s2_load = s1_adv && s1_prod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (s2_rdy) begin
      s2_valid_r <= s2_load;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      for (int k = 0; k < KERNEL; k++) begin
        for (int l = 0; l < KERNEL; l++) begin
          prod_r[k*KERNEL+l] <= prod_t'($signed({1'b0, win_nxt[k][l]}))
                              * prod_t'(coef_r[k*KERNEL+l]);
        end
      end
      s2_base_r       <= s1_base_r;
      s2_row_last_r   <= s1_row_last_r;
      s2_frame_last_r <= s1_frame_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: one sum per kernel row
  // ---------------------------------------------------------------------
  row_sum_t           rsum_r [KERNEL];
  row_sum_t           rsum_nxt [KERNEL];
  logic signed [31:0] s3_base_r;
  logic               s3_row_last_r, s3_frame_last_r;
  logic               s3_load;

  assign s3_load = s2_valid_r && s3_rdy;

  always_comb begin
    for (int k = 0; k < KERNEL; k++) begin
      rsum_nxt[k] = '0;
      for (int l = 0; l < KERNEL; l++) begin
        rsum_nxt[k] = rsum_nxt[k] + row_sum_t'(prod_r[k*KERNEL+l]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else if (s3_rdy) begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_load) begin
      rsum_r          <= rsum_nxt;
      s3_base_r       <= s2_base_r;
      s3_row_last_r   <= s2_row_last_r;
      s3_frame_last_r <= s2_frame_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: full window sum
  // ---------------------------------------------------------------------
  acc_t               acc_r, acc_nxt;
  logic signed [31:0] s4_base_r;
  logic               s4_row_last_r, s4_frame_last_r;
  logic               s4_load;

  assign s4_load = s3_valid_r && s4_rdy;

  always_comb begin
    acc_nxt = '0;
    for (int k = 0; k < KERNEL; k++) begin
      acc_nxt = acc_nxt + acc_t'(rsum_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_valid_r <= 1'b0;
    end else if (s4_rdy) begin
      s4_valid_r <= s3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_load) begin
      acc_r           <= acc_nxt;
      s4_base_r       <= s3_base_r;
      s4_row_last_r   <= s3_row_last_r;
      s4_frame_last_r <= s3_frame_last_r;
    end
  end

  // ---------------------------------------------------------------------
  // Output stage: Q1.15 scaling (floor), base addend, saturation
  // ---------------------------------------------------------------------
  acc_t               acc_shift;
  total_t             total;
  logic signed [31:0] sat_val;
  logic signed [31:0] filtered_r;
  logic               row_last_r, frame_last_r;
  logic               out_load;

  assign out_load  = s4_valid_r && out_rdy;
  assign acc_shift = acc_r >>> FRAC_W;
  assign total     = total_t'(acc_shift) + total_t'(s4_base_r);

  always_comb begin
    if (total > total_t'(34'sh0_7FFF_FFFF)) begin
      sat_val = 32'sh7FFF_FFFF;
    end else if (total < total_t'(-34'sh0_8000_0000)) begin
      sat_val = 32'sh8000_0000;
    end else begin
      sat_val = total[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_rdy) begin
      out_valid_r <= s4_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      filtered_r   <= sat_val;
      row_last_r   <= s4_row_last_r;
      frame_last_r <= s4_frame_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_filtered   = filtered_r;
  assign out_row_last   = row_last_r;
  assign out_frame_last = frame_last_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  // The line store is never written back by the pipeline during the clear.
  a_no_wb_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clear_r |-> !s1_valid_r)
    else $error("pipeline write-back during line store clear");

  // The last window of a frame is always the last window of its row.
  a_frame_implies_row: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_frame_last) |-> out_row_last)
    else $error("frame_last without row_last");

  // A new result only follows a full window sum in the previous stage.
  a_out_from_s4: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s4_valid_r))
    else $error("result appeared without a window sum");

endmodule

`default_nettype wire
